@@ src/quaternion_vector_rotate_unit_assert.svh @@
// Assertion macros for the quaternion vector rotate unit.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QVR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qvr assertion failed");
`define QVR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qvr assertion failed");
`else
`define QVR_ASSERT(lbl, clk, rst_n, prop)
`define QVR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ src/qvr_pkg.sv @@
// Package for the quaternion vector rotate unit: payload types, constants
// and multiply helpers. Depends on nothing.
`default_nettype none
package qvr_pkg;

    localparam int VEC_W    = 24;
    localparam int QUAT_W   = 16;
    localparam int NORM_W   = 33;
    localparam int T_W      = 42;
    localparam int R_W      = 60;
    localparam int DIV_BITS = 25;
    localparam int REM_W    = 58;
    localparam int XF_LAT   = 4;
    localparam int LATENCY  = XF_LAT + DIV_BITS + 3;

    localparam logic [NORM_W-1:0] NORM_FLOOR = 33'd268;
    localparam logic [VEC_W-1:0]  OUT_MAX    = 24'h7FFFFF;
    localparam logic [VEC_W-1:0]  OUT_MIN    = 24'h800000;

    localparam logic [1:0] REG_QUAT_W = 2'd0;
    localparam logic [1:0] REG_QUAT_X = 2'd1;
    localparam logic [1:0] REG_QUAT_Y = 2'd2;
    localparam logic [1:0] REG_QUAT_Z = 2'd3;

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic signed [VEC_W-1:0] rot_z;
        logic                    saturated;
    } t_vec_out;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } t_quat;

    function automatic logic signed [39:0] mul_qv(input logic signed [QUAT_W-1:0] a,
                                                  input logic signed [VEC_W-1:0] b);
        return 40'(a) * 40'(b);
    endfunction

    function automatic logic signed [REM_W-1:0] mul_tq(input logic signed [T_W-1:0] a,
                                                       input logic signed [QUAT_W-1:0] b);
        return 58'(a) * 58'(b);
    endfunction

endpackage
`default_nettype wire

@@ src/qvr_norm.sv @@
// Configuration registers and the registered, floored squared norm of q.
// Depends on qvr_pkg.
`default_nettype none
module qvr_norm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [15:0]                 i_cfg_data,
    output qvr_pkg::t_quat                   o_quat,
    output logic [qvr_pkg::NORM_W-1:0]       o_norm
);
    import qvr_pkg::*;

    t_quat             r_quat;
    logic [31:0]       r_sq [4];
    logic [NORM_W-1:0] r_norm;
    logic [NORM_W-1:0] n_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat <= '{w: 16'sd16384, x: '0, y: '0, z: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_QUAT_W: r_quat.w <= i_cfg_data;
                REG_QUAT_X: r_quat.x <= i_cfg_data;
                REG_QUAT_Y: r_quat.y <= i_cfg_data;
                REG_QUAT_Z: r_quat.z <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_norm = 33'(r_sq[0]) + 33'(r_sq[1]) + 33'(r_sq[2]) + 33'(r_sq[3]);
        if (n_norm < NORM_FLOOR) begin
            n_norm = NORM_FLOOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0] <= 32'd268435456;
            r_sq[1] <= '0;
            r_sq[2] <= '0;
            r_sq[3] <= '0;
            r_norm  <= 33'd268435456;
        end else begin
            r_sq[0] <= 32'(32'(r_quat.w) * 32'(r_quat.w));
            r_sq[1] <= 32'(32'(r_quat.x) * 32'(r_quat.x));
            r_sq[2] <= 32'(32'(r_quat.y) * 32'(r_quat.y));
            r_sq[3] <= 32'(32'(r_quat.z) * 32'(r_quat.z));
            r_norm  <= n_norm;
        end
    end

    assign o_quat = r_quat;
    assign o_norm = r_norm;
endmodule
`default_nettype wire

@@ src/qvr_xform.sv @@
// Four-stage pipeline forming the vector part of q * p * conj(q), with 28 more fraction bits than i_vec.
// Depends on qvr_pkg.
`default_nettype none
module qvr_xform (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire qvr_pkg::t_vec_in              i_vec,
    input  wire qvr_pkg::t_quat                i_quat,
    output logic                               o_valid,
    output logic signed [qvr_pkg::R_W-1:0]     o_rx,
    output logic signed [qvr_pkg::R_W-1:0]     o_ry,
    output logic signed [qvr_pkg::R_W-1:0]     o_rz
);
    import qvr_pkg::*;

    logic [XF_LAT-1:0]        r_vld;
    logic signed [39:0]       r_p [12];
    logic signed [T_W-1:0]    r_tw, r_tx, r_ty, r_tz;
    logic signed [REM_W-1:0]  r_m [12];
    logic signed [R_W-1:0]    r_rx, r_ry, r_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[XF_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0]  <= mul_qv(i_quat.x, i_vec.vec_x);
        r_p[1]  <= mul_qv(i_quat.y, i_vec.vec_y);
        r_p[2]  <= mul_qv(i_quat.z, i_vec.vec_z);
        r_p[3]  <= mul_qv(i_quat.w, i_vec.vec_x);
        r_p[4]  <= mul_qv(i_quat.y, i_vec.vec_z);
        r_p[5]  <= mul_qv(i_quat.z, i_vec.vec_y);
        r_p[6]  <= mul_qv(i_quat.w, i_vec.vec_y);
        r_p[7]  <= mul_qv(i_quat.x, i_vec.vec_z);
        r_p[8]  <= mul_qv(i_quat.z, i_vec.vec_x);
        r_p[9]  <= mul_qv(i_quat.w, i_vec.vec_z);
        r_p[10] <= mul_qv(i_quat.x, i_vec.vec_y);
        r_p[11] <= mul_qv(i_quat.y, i_vec.vec_x);

        r_tw <= -42'(r_p[0]) - 42'(r_p[1]) - 42'(r_p[2]);
        r_tx <=  42'(r_p[3]) + 42'(r_p[4]) - 42'(r_p[5]);
        r_ty <=  42'(r_p[6]) - 42'(r_p[7]) + 42'(r_p[8]);
        r_tz <=  42'(r_p[9]) + 42'(r_p[10]) - 42'(r_p[11]);

        r_m[0]  <= mul_tq(r_tw, i_quat.x);
        r_m[1]  <= mul_tq(r_tx, i_quat.w);
        r_m[2]  <= mul_tq(r_ty, i_quat.z);
        r_m[3]  <= mul_tq(r_tz, i_quat.y);
        r_m[4]  <= mul_tq(r_tw, i_quat.y);
        r_m[5]  <= mul_tq(r_tx, i_quat.z);
        r_m[6]  <= mul_tq(r_ty, i_quat.w);
        r_m[7]  <= mul_tq(r_tz, i_quat.x);
        r_m[8]  <= mul_tq(r_tw, i_quat.z);
        r_m[9]  <= mul_tq(r_tx, i_quat.y);
        r_m[10] <= mul_tq(r_ty, i_quat.x);
        r_m[11] <= mul_tq(r_tz, i_quat.w);

        r_rx <= -60'(r_m[0]) + 60'(r_m[1]) - 60'(r_m[2]) + 60'(r_m[3]);
        r_ry <= -60'(r_m[4]) + 60'(r_m[5]) + 60'(r_m[6]) - 60'(r_m[7]);
        r_rz <= -60'(r_m[8]) - 60'(r_m[9]) + 60'(r_m[10]) + 60'(r_m[11]);
    end

    assign o_valid = r_vld[XF_LAT-1];
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_rz    = r_rz;
endmodule
`default_nettype wire

@@ src/qvr_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, rounding to
// nearest with ties away from zero, and saturation to 24 bits. Depends on qvr_pkg.
`default_nettype none
module qvr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [qvr_pkg::R_W-1:0] i_num,
    input  wire logic [qvr_pkg::NORM_W-1:0]    i_norm,
    output logic                               o_valid,
    output logic signed [qvr_pkg::VEC_W-1:0]   o_value,
    output logic                               o_sat
);
    import qvr_pkg::*;

    logic                    r_vld_a;
    logic                    r_neg_a;
    logic [R_W:0]            r_dvd;
    logic [R_W-1:0]          n_mag;
    logic [R_W:0]            n_lim;

    logic [DIV_BITS:0]       r_vld;
    logic                    r_neg [DIV_BITS+1];
    logic                    r_ovf [DIV_BITS+1];
    logic [REM_W-1:0]        r_rem [DIV_BITS+1];
    logic [DIV_BITS-1:0]     r_q   [DIV_BITS+1];

    logic                    r_vld_o;
    logic signed [VEC_W-1:0] r_value;
    logic                    r_sat;
    logic [DIV_BITS-1:0]     w_q;
    logic                    n_sat;
    logic [VEC_W-1:0]        n_value;

    assign n_mag = i_num[R_W-1] ? 60'(-i_num) : 60'(i_num);
    assign n_lim = {3'b000, i_norm, 25'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a  <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r_vld_a  <= i_valid;
            r_vld[0] <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_a  <= i_num[R_W-1];
        r_dvd    <= {1'b0, n_mag} + {29'd0, i_norm[NORM_W-1:1]};
        r_neg[0] <= r_neg_a;
        r_ovf[0] <= (r_dvd >= n_lim);
        r_rem[0] <= r_dvd[REM_W-1:0];
        r_q[0]   <= '0;
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_step
        localparam int B = DIV_BITS - 1 - g;
        logic [REM_W-1:0] w_sub;
        logic             w_ge;

        assign w_sub = REM_W'(i_norm) << B;
        assign w_ge  = (r_rem[g] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[g+1] <= r_neg[g];
            r_ovf[g+1] <= r_ovf[g];
            r_rem[g+1] <= w_ge ? r_rem[g] - w_sub : r_rem[g];
            r_q[g+1]   <= r_q[g] | (DIV_BITS'(w_ge) << B);
        end
    end

    assign w_q = r_q[DIV_BITS];

    always_comb begin
        if (r_neg[DIV_BITS]) begin
            n_sat   = r_ovf[DIV_BITS] || (w_q > 25'd8388608);
            n_value = n_sat ? OUT_MIN : VEC_W'(-w_q);
        end else begin
            n_sat   = r_ovf[DIV_BITS] || (w_q > 25'd8388607);
            n_value = n_sat ? OUT_MAX : w_q[VEC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else begin
            r_vld_o <= r_vld[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_valid = r_vld_o;
    assign o_value = r_value;
    assign o_sat   = r_sat;
endmodule
`default_nettype wire

@@ src/quaternion_vector_rotate_unit.sv @@
// Top level of the quaternion vector rotate unit: rotates vectors by q.
// Depends on qvr_pkg, qvr_norm, qvr_xform, qvr_div and the assertion header.
//
//   channel   handshake            payload
//   input     start, busy          i_vec   (t_vec_in)
//   result    o_valid (strobe)     o_result (t_vec_out)
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// A vector transfer can occur every cycle; busy is always low.
// Each result passes from its input transfer through the 4-stage multiply pipeline
// and the divider, whose 25 step stages each form one quotient bit.
// Reset is synchronous and clears the valid bits and loads q = 1.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "quaternion_vector_rotate_unit_assert.svh"
module quaternion_vector_rotate_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire qvr_pkg::t_vec_in  i_vec,
    output logic                   o_valid,
    output qvr_pkg::t_vec_out      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data
);
    import qvr_pkg::*;

    t_quat                 w_quat;
    logic [NORM_W-1:0]     w_norm;
    logic                  w_xf_vld;
    logic signed [R_W-1:0] w_rx, w_ry, w_rz;
    logic [2:0]            w_vld;
    logic [2:0]            w_sat;
    logic                  w_at_bound;

    assign busy = 1'b0;

    qvr_norm u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_quat     (w_quat),
        .o_norm     (w_norm)
    );

    qvr_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_vec   (i_vec),
        .i_quat  (w_quat),
        .o_valid (w_xf_vld),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_rz    (w_rz)
    );

    qvr_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_xf_vld), .i_num (w_rx),
        .i_norm (w_norm), .o_valid (w_vld[0]), .o_value (o_result.rot_x),
        .o_sat (w_sat[0])
    );

    qvr_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_xf_vld), .i_num (w_ry),
        .i_norm (w_norm), .o_valid (w_vld[1]), .o_value (o_result.rot_y),
        .o_sat (w_sat[1])
    );

    qvr_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_xf_vld), .i_num (w_rz),
        .i_norm (w_norm), .o_valid (w_vld[2]), .o_value (o_result.rot_z),
        .o_sat (w_sat[2])
    );

    assign o_valid            = w_vld[0];
    assign o_result.saturated = |w_sat;

    assign w_at_bound = (o_result.rot_x == OUT_MAX) || (o_result.rot_x == OUT_MIN)
                     || (o_result.rot_y == OUT_MAX) || (o_result.rot_y == OUT_MIN)
                     || (o_result.rot_z == OUT_MAX) || (o_result.rot_z == OUT_MIN);

    `QVR_ASSERT(a_lanes_aligned, i_clk, i_rst_n, (w_vld[0] == w_vld[1]) && (w_vld[1] == w_vld[2]))
    `QVR_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##LATENCY o_valid)
    `QVR_ASSERT(a_sat_at_bound, i_clk, i_rst_n, (o_valid && o_result.saturated) |-> w_at_bound)
endmodule
`default_nettype wire
